/* sv/http_request_framer_assert.svh */
// ---------------------------------------------------------------------------
// HTTP request framer assertion macros
// Shared property forms for the framer's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef HTTP_REQUEST_FRAMER_ASSERT_SVH
`define HTTP_REQUEST_FRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HRF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hrf_pkg.sv */
// ---------------------------------------------------------------------------
// HTTP request framer package
// Types, character codes and the header name table shared by the framer.
// ---------------------------------------------------------------------------
package hrf_pkg;

  localparam int COUNT_BITS = 24;
  localparam int NAME_LEN   = 15;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;

  localparam logic [COUNT_BITS-1:0] BYTE_LIMIT_RESET = 24'd65536;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] REASON_NONE   = 3'd0;
  localparam logic [2:0] REASON_BODY   = 3'd1;
  localparam logic [2:0] REASON_NOLEN  = 3'd2;
  localparam logic [2:0] REASON_LIMIT  = 3'd3;
  localparam logic [2:0] REASON_STREAM = 3'd4;

  // Classified input item, built by the front end.
  typedef struct packed {
    logic [7:0] data;
    logic       stream_end;
    logic       is_cr;
    logic       is_lf;
    logic       is_digit;
    logic       is_blank;
    logic       is_sign;
    logic       is_minus;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic [7:0]            byte_out;
    logic [COUNT_BITS-1:0] byte_index;
    logic                  body_byte;
    logic                  request_done;
    logic [2:0]            done_reason;
    logic [COUNT_BITS-1:0] header_length;
    logic [COUNT_BITS-1:0] body_length;
    logic                  length_valid;
  } result_t;

  // Character of the header name at a position; lower selects the all-lowercase spelling.
  function automatic logic [7:0] name_char(input logic lower, input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = lower ? "c" : "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = lower ? "l" : "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* sv/hrf_front.sv */
// ---------------------------------------------------------------------------
// HTTP request framer front end
// Classifies each incoming byte into the flags the parser needs.
// ---------------------------------------------------------------------------
module hrf_front
  import hrf_pkg::*;
(
  input  logic [7:0] data_byte,
  input  logic       stream_end,
  output item_t      item
);

  logic [7:0] offset;

  assign offset = data_byte - CH_ZERO;

  always_comb begin
    item.data       = data_byte;
    item.stream_end = stream_end;
    item.is_cr      = (data_byte == CH_CR);
    item.is_lf      = (data_byte == CH_LF);
    item.is_digit   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    item.is_blank   = (data_byte == CH_SPACE) || (data_byte == CH_TAB);
    item.is_sign    = (data_byte == CH_PLUS) || (data_byte == CH_MINUS);
    item.is_minus   = (data_byte == CH_MINUS);
    item.digit      = offset[3:0];
  end

endmodule

/* sv/hrf_queue.sv */
// ---------------------------------------------------------------------------
// HTTP request framer item queue
// Short queue of classified items between the front end and the parser.
// ---------------------------------------------------------------------------
module hrf_queue
  import hrf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_item,
  output logic  not_empty
);

  item_t                slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full      = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rd_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/hrf_back.sv */
// ---------------------------------------------------------------------------
// HTTP request framer parser
// Per-request framing, one item per cycle; an unpopped held result stalls it.
// ---------------------------------------------------------------------------
module hrf_back
  import hrf_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [COUNT_BITS-1:0] byte_limit,
  input  logic                  in_valid,
  input  item_t                 in_item,
  output logic                  take,
  output logic                  out_valid,
  input  logic                  out_pop,
  output result_t               res
);

  localparam int SUM_BITS = ((LENGTH_BITS > COUNT_BITS) ? LENGTH_BITS : COUNT_BITS) + 1;
  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

  // Value scan phases.
  localparam logic [1:0] VP_IDLE  = 2'd0;
  localparam logic [1:0] VP_BLANK = 2'd1;
  localparam logic [1:0] VP_DIGIT = 2'd2;
  localparam logic [1:0] VP_DONE  = 2'd3;

  logic [COUNT_BITS-1:0]  byte_count, byte_count_next;
  logic [1:0]             terminator_progress, terminator_progress_next;
  logic                   headers_complete, headers_complete_next;
  logic                   line_start, line_start_next;
  logic [3:0]             name_position, name_position_next;
  logic [1:0]             spellings_alive, spellings_alive_next;
  logic [1:0]             value_phase, value_phase_next;
  logic                   value_negative, value_negative_next;
  logic                   length_found, length_found_next;
  logic [LENGTH_BITS-1:0] length_value, length_value_next;
  logic [COUNT_BITS-1:0]  terminator_offset, terminator_offset_next;
  result_t                res_next;

  logic [LENGTH_BITS+3:0]            acc;
  logic [LENGTH_BITS+COUNT_BITS-1:0] length_ext;
  logic [SUM_BITS-1:0]               body_end;
  logic                              accumulate;
  logic                              finish;
  logic [1:0]                        alive;
  logic [2:0]                        reason;

  assign take = in_valid && (!out_valid || out_pop);

  always_comb begin
    byte_count_next          = byte_count;
    terminator_progress_next = terminator_progress;
    headers_complete_next    = headers_complete;
    line_start_next          = line_start;
    name_position_next       = name_position;
    spellings_alive_next     = spellings_alive;
    value_phase_next         = value_phase;
    value_negative_next      = value_negative;
    length_found_next        = length_found;
    length_value_next        = length_value;
    terminator_offset_next   = terminator_offset;
    accumulate = 1'b0;
    finish     = 1'b0;
    alive      = 2'b00;
    acc        = '0;
    body_end   = '0;
    reason     = REASON_NONE;

    if (!in_item.stream_end) begin
      byte_count_next = byte_count + 1'b1;
      if (!headers_complete) begin
        if (line_start) begin
          name_position_next   = '0;
          spellings_alive_next = 2'b11;
          line_start_next      = 1'b0;
        end

        unique case (value_phase)
          VP_BLANK: begin
            if (in_item.is_blank) begin
              value_phase_next = VP_BLANK;
            end else if (in_item.is_sign) begin
              value_negative_next = in_item.is_minus;
              value_phase_next    = VP_DIGIT;
            end else if (in_item.is_digit) begin
              value_phase_next = VP_DIGIT;
              accumulate       = 1'b1;
            end else begin
              finish = 1'b1;
            end
          end
          VP_DIGIT: begin
            if (in_item.is_digit) begin
              accumulate = 1'b1;
            end else begin
              finish = 1'b1;
            end
          end
          VP_IDLE: begin
            if ((spellings_alive_next != 2'b00) &&
                (name_position_next < 4'(NAME_LEN))) begin
              alive = spellings_alive_next;
              if (in_item.data != name_char(1'b0, name_position_next)) begin
                alive[0] = 1'b0;
              end
              if (in_item.data != name_char(1'b1, name_position_next)) begin
                alive[1] = 1'b0;
              end
              spellings_alive_next = alive;
              name_position_next   = name_position_next + 1'b1;
              if ((alive != 2'b00) && (name_position_next == 4'(NAME_LEN))) begin
                value_phase_next    = VP_BLANK;
                value_negative_next = 1'b0;
                length_value_next   = '0;
              end
            end
          end
          default: begin
            value_phase_next = VP_DONE;
          end
        endcase

        // Decimal accumulate with saturation: value * 8 + value * 2 + digit.
        if (accumulate) begin
          acc = ({4'b0, length_value} << 3) + ({4'b0, length_value} << 1) +
                (LENGTH_BITS+4)'(in_item.digit);
          length_value_next = (acc > {4'b0, LENGTH_MAX}) ? LENGTH_MAX
                                                         : acc[LENGTH_BITS-1:0];
        end
        if (finish) begin
          length_found_next = !(value_negative_next && (length_value != '0));
          if (!length_found_next) begin
            length_value_next = '0;
          end
          value_phase_next = VP_DONE;
        end

        if (in_item.is_cr) begin
          terminator_progress_next = (terminator_progress == 2'd2) ? 2'd3 : 2'd1;
        end else if (in_item.is_lf && (terminator_progress == 2'd1)) begin
          terminator_progress_next = 2'd2;
        end else if (in_item.is_lf && (terminator_progress == 2'd3)) begin
          headers_complete_next    = 1'b1;
          terminator_offset_next   = byte_count_next;
          terminator_progress_next = 2'd0;
        end else begin
          terminator_progress_next = 2'd0;
        end
        if (terminator_progress_next == 2'd2) begin
          line_start_next = 1'b1;
        end
      end

      body_end = SUM_BITS'(terminator_offset_next) + SUM_BITS'(length_value_next);
      if (headers_complete_next && !headers_complete && !length_found_next) begin
        reason = REASON_NOLEN;
      end else if (headers_complete_next && length_found_next &&
                   (SUM_BITS'(byte_count_next) >= body_end)) begin
        reason = REASON_BODY;
      end else if (byte_count_next >= byte_limit) begin
        reason = REASON_LIMIT;
      end
    end else begin
      reason = REASON_STREAM;
    end
  end

  assign length_ext = {{COUNT_BITS{1'b0}}, length_value_next};

  always_comb begin
    res_next.byte_out      = in_item.stream_end ? 8'h00 : in_item.data;
    res_next.byte_index    = byte_count;
    res_next.body_byte     = in_item.stream_end ? 1'b0 : headers_complete;
    res_next.request_done  = (reason != REASON_NONE);
    res_next.done_reason   = reason;
    res_next.header_length = headers_complete_next ? terminator_offset_next : '0;
    res_next.body_length   = length_found_next ? length_ext[COUNT_BITS-1:0] : '0;
    res_next.length_valid  = length_found_next;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && (reason != REASON_NONE))) begin
      byte_count          <= '0;
      terminator_progress <= '0;
      headers_complete    <= 1'b0;
      line_start          <= 1'b1;
      name_position       <= '0;
      spellings_alive     <= 2'b11;
      value_phase         <= VP_IDLE;
      value_negative      <= 1'b0;
      length_found        <= 1'b0;
      length_value        <= '0;
      terminator_offset   <= '0;
    end else if (take) begin
      byte_count          <= byte_count_next;
      terminator_progress <= terminator_progress_next;
      headers_complete    <= headers_complete_next;
      line_start          <= line_start_next;
      name_position       <= name_position_next;
      spellings_alive     <= spellings_alive_next;
      value_phase         <= value_phase_next;
      value_negative      <= value_negative_next;
      length_found        <= length_found_next;
      length_value        <= length_value_next;
      terminator_offset   <= terminator_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* sv/http_request_framer.sv */
// ---------------------------------------------------------------------------
// HTTP request framer
// Frames HTTP/1.1 requests on a byte stream using the Content-Length header.
// ---------------------------------------------------------------------------
// Channel   Handshake            Payload
// input     push / full          data_byte, stream_end
// result    pop / empty          byte_out .. length_valid
// config    cfg_valid/cfg_ready  cfg_limit
//
// One item per cycle is sustained while pop keeps up; the parser state update in hrf_back sets this.
// An accepted item is first written into the four-entry queue, then loads the result
// register when the parser takes it from the queue.
// Stalls on pop back up into the queue; full rises only when it holds four items.
// Reset clears the queue, the result valid flag and the request state, and loads
// a byte limit of 65536.
// ---------------------------------------------------------------------------
`include "http_request_framer_assert.svh"

module http_request_framer
  import hrf_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            data_byte,
  input  logic                  stream_end,
  input  logic                  pop,
  output logic                  empty,
  output logic [7:0]            byte_out,
  output logic [COUNT_BITS-1:0] byte_index,
  output logic                  body_byte,
  output logic                  request_done,
  output logic [2:0]            done_reason,
  output logic [COUNT_BITS-1:0] header_length,
  output logic [COUNT_BITS-1:0] body_length,
  output logic                  length_valid,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COUNT_BITS-1:0] cfg_limit
);

  item_t                 front_item;
  item_t                 queue_item;
  logic                  queue_not_empty;
  logic                  take;
  logic                  out_valid;
  result_t               res;
  logic [COUNT_BITS-1:0] byte_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit <= BYTE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      byte_limit <= cfg_limit;
    end
  end

  hrf_front u_front (
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .item       (front_item)
  );

  hrf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (push && !full),
    .wr_item   (front_item),
    .full      (full),
    .rd_en     (take),
    .rd_item   (queue_item),
    .not_empty (queue_not_empty)
  );

  hrf_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .byte_limit (byte_limit),
    .in_valid   (queue_not_empty),
    .in_item    (queue_item),
    .take       (take),
    .out_valid  (out_valid),
    .out_pop    (pop),
    .res        (res)
  );

  assign empty         = !out_valid;
  assign byte_out      = res.byte_out;
  assign byte_index    = res.byte_index;
  assign body_byte     = res.body_byte;
  assign request_done  = res.request_done;
  assign done_reason   = res.done_reason;
  assign header_length = res.header_length;
  assign body_length   = res.body_length;
  assign length_valid  = res.length_valid;

  // An accepted item is waiting in the queue on the following cycle.
  `HRF_ASSERT_NEXT(a_push_lands, clk, rst, push && !full, queue_not_empty, "item lost at queue")
  // A stream-end result carries no byte and is never a body byte.
  `HRF_ASSERT_IMPL(a_stream_end_clean, clk, rst, !empty && (done_reason == REASON_STREAM), (byte_out == 8'h00) && !body_byte, "stream end result carries data")
  // A body byte can only follow a found header terminator.
  `HRF_ASSERT_IMPL(a_body_has_header, clk, rst, !empty && body_byte, header_length != '0, "body byte without header terminator")
  // A length is reported only together with its valid flag.
  `HRF_ASSERT_IMPL(a_length_gated, clk, rst, !empty && !length_valid, body_length == '0, "length reported while not valid")

endmodule
